// ===== sv/assert_macros.svh =====
// assertion macros for the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CSC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `CSC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== sv/csc_pkg.sv =====
// package for the color space converter: payload types, codes and helpers
`default_nettype none

package csc_pkg;

    // color space codes
    typedef enum logic [1:0] {
        SP_GRAY = 2'd0,
        SP_RGB  = 2'd1,
        SP_CMYK = 2'd2,
        SP_BAD  = 2'd3
    } t_space;

    // luma weights, scaled by 1000
    localparam logic [9:0]  GRAY_W_R   = 10'd299;
    localparam logic [9:0]  GRAY_W_G   = 10'd587;
    localparam logic [9:0]  GRAY_W_B   = 10'd114;
    localparam logic [9:0]  GRAY_DIV   = 10'd1000;
    // floor(2^20 / 1000): estimate is exact or one low
    localparam logic [10:0] GRAY_RECIP = 11'd1048;
    localparam int          GRAY_SHIFT = 20;

    typedef struct packed {
        logic [1:0] src_space;
        logic [1:0] dst_space;
        logic [7:0] in_alpha;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_cyan;
        logic [7:0] in_magenta;
        logic [7:0] in_yellow;
        logic [7:0] in_black;
    } t_csc_in;

    typedef struct packed {
        logic [1:0]  out_space;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_cyan;
        logic [7:0]  out_magenta;
        logic [7:0]  out_yellow;
        logic [7:0]  out_black;
        logic [31:0] argb_word;
        logic        bad_space;
    } t_csc_out;

    // floor(p / 255), exact for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] w;
        w = 17'(p) + 17'(p[15:8]) + 17'd1;
        return w[15:8];
    endfunction

    // two restoring division steps, returns {quotient bits, remainder}
    function automatic logic [9:0] div2(input logic [7:0] rem, input logic [1:0] bits,
                                        input logic [7:0] den);
        logic [8:0] w;
        logic [7:0] r;
        logic [1:0] q;
        r = rem;
        q = 2'b00;
        for (int i = 1; i >= 0; i--) begin
            w = {r, bits[i]};
            if (w >= {1'b0, den}) begin
                q[i] = 1'b1;
                w    = w - {1'b0, den};
            end
            r = w[7:0];
        end
        return {q, r};
    endfunction

endpackage

`default_nettype wire

// ===== sv/color_space_converter.sv =====
// color space converter top level: nine-stage pixel pipeline
//
//  channel  | direction | signals                  | transfer
//  ---------+-----------+--------------------------+---------------------------
//  command  | in        | start, busy, i_item      | edge with start=1, busy=0
//  result   | out       | o_done, o_result         | edge ending an o_done cycle
//
//  nine register stages, r_s1 to r_s8 and then the output register; the depth is
//  set by the four two-bit stages of the rgb to cmyk divider and the
//  weighted-sum/reciprocal stages of the gray path
//  one pixel per clock is sustained: every stage takes a new pixel each clock
//  busy is always low: nothing in the pipe ever has to wait
//  synchronous active-low reset clears the valid bits only; data regs hold junk
//  the receiver cannot stall, so each result shows for exactly one cycle
`default_nettype none

`include "assert_macros.svh"

module color_space_converter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  csc_pkg::t_csc_in    i_item,
    output logic                o_done,
    output csc_pkg::t_csc_out   o_result
);
    import csc_pkg::*;

    localparam int NSTG = 8;

    // one record carried down the pipe; each stage fills in its own fields
    typedef struct packed {
        logic [1:0]       src;
        logic [1:0]       dst;
        logic [7:0]       alpha;
        // source channels (all raw channels when the source code is illegal)
        logic [7:0]       s_r, s_g, s_b, s_c, s_m, s_y, s_k;
        // products feeding a divide by 255
        logic [2:0][15:0] prod;
        // source color as rgb
        logic [7:0]       t_r, t_g, t_b;
        // gray path
        logic [17:0]      wsum;
        logic [7:0]       gray;
        // rgb to cmyk path
        logic [7:0]       mx;
        logic             blk;
        logic [2:0][15:0] num;
        logic [2:0][7:0]  rem;
        logic [2:0][7:0]  quo;
        // result color
        logic [1:0]       space;
        logic [7:0]       d_r, d_g, d_b, d_c, d_m, d_y, d_k;
    } t_pipe;

    t_pipe r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;
    t_pipe n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
    logic [NSTG-1:0] r_vld, n_vld;
    t_csc_out r_out, n_out;
    logic     r_done;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: decode spaces, pick source channels, cmyk to rgb products
    always_comb begin
        n_s1       = r_s1;
        n_s1.src   = i_item.src_space;
        n_s1.dst   = i_item.dst_space;
        n_s1.alpha = i_item.in_alpha;
        n_s1.s_r   = 8'd0;
        n_s1.s_g   = 8'd0;
        n_s1.s_b   = 8'd0;
        n_s1.s_c   = 8'd0;
        n_s1.s_m   = 8'd0;
        n_s1.s_y   = 8'd0;
        n_s1.s_k   = 8'd0;
        case (i_item.src_space)
            SP_GRAY: begin
                n_s1.s_g = i_item.in_green;
            end
            SP_RGB: begin
                n_s1.s_r = i_item.in_red;
                n_s1.s_g = i_item.in_green;
                n_s1.s_b = i_item.in_blue;
            end
            SP_CMYK: begin
                n_s1.s_c = i_item.in_cyan;
                n_s1.s_m = i_item.in_magenta;
                n_s1.s_y = i_item.in_yellow;
                n_s1.s_k = i_item.in_black;
            end
            default: begin
                // illegal source: every raw channel passes through
                n_s1.s_r = i_item.in_red;
                n_s1.s_g = i_item.in_green;
                n_s1.s_b = i_item.in_blue;
                n_s1.s_c = i_item.in_cyan;
                n_s1.s_m = i_item.in_magenta;
                n_s1.s_y = i_item.in_yellow;
                n_s1.s_k = i_item.in_black;
            end
        endcase
        // (255-k)(255-x) per channel
        n_s1.prod[0] = 16'(8'hff - i_item.in_black) * 16'(8'hff - i_item.in_cyan);
        n_s1.prod[1] = 16'(8'hff - i_item.in_black) * 16'(8'hff - i_item.in_magenta);
        n_s1.prod[2] = 16'(8'hff - i_item.in_black) * 16'(8'hff - i_item.in_yellow);
    end

    // stage 2: source color as rgb
    always_comb begin
        n_s2 = r_s1;
        case (r_s1.src)
            SP_CMYK: begin
                n_s2.t_r = div255(r_s1.prod[0]);
                n_s2.t_g = div255(r_s1.prod[1]);
                n_s2.t_b = div255(r_s1.prod[2]);
            end
            SP_GRAY: begin
                n_s2.t_r = r_s1.s_g;
                n_s2.t_g = r_s1.s_g;
                n_s2.t_b = r_s1.s_g;
            end
            default: begin
                n_s2.t_r = r_s1.s_r;
                n_s2.t_g = r_s1.s_g;
                n_s2.t_b = r_s1.s_b;
            end
        endcase
    end

    // stage 3: luma weighted sum, max channel and divider numerators
    always_comb begin
        logic [7:0] mx;
        logic [7:0] diff [3];
        n_s3      = r_s2;
        n_s3.wsum = 18'(r_s2.t_r) * 18'(GRAY_W_R)
                  + 18'(r_s2.t_g) * 18'(GRAY_W_G)
                  + 18'(r_s2.t_b) * 18'(GRAY_W_B);
        mx = r_s2.t_r;
        if (r_s2.t_g > mx) begin
            mx = r_s2.t_g;
        end
        if (r_s2.t_b > mx) begin
            mx = r_s2.t_b;
        end
        n_s3.mx  = mx;
        n_s3.blk = (mx == 8'd0);
        diff[0]  = mx - r_s2.t_r;
        diff[1]  = mx - r_s2.t_g;
        diff[2]  = mx - r_s2.t_b;
        for (int i = 0; i < 3; i++) begin
            // diff * 255, which stays below 256 * mx
            n_s3.num[i] = {diff[i], 8'd0} - {8'd0, diff[i]};
            n_s3.rem[i] = n_s3.num[i][15:8];
            n_s3.quo[i] = 8'd0;
        end
    end

    // stage 4: reciprocal estimate of the gray level, divider bits 7..6
    always_comb begin
        logic [28:0] est;
        logic [9:0]  st;
        n_s4      = r_s3;
        est       = 29'(r_s3.wsum) * 29'(GRAY_RECIP);
        n_s4.gray = 8'(est >> GRAY_SHIFT);
        for (int i = 0; i < 3; i++) begin
            st          = div2(r_s3.rem[i], r_s3.num[i][7:6], r_s3.mx);
            n_s4.rem[i] = st[7:0];
            n_s4.quo[i] = {r_s3.quo[i][5:0], st[9:8]};
        end
    end

    // stage 5: gray correction, divider bits 5..4
    always_comb begin
        logic [17:0] left;
        logic [9:0]  st;
        n_s5 = r_s4;
        left = r_s4.wsum - 18'(r_s4.gray) * 18'(GRAY_DIV);
        if (left >= 18'(GRAY_DIV)) begin
            n_s5.gray = r_s4.gray + 8'd1;
        end
        for (int i = 0; i < 3; i++) begin
            st          = div2(r_s4.rem[i], r_s4.num[i][5:4], r_s4.mx);
            n_s5.rem[i] = st[7:0];
            n_s5.quo[i] = {r_s4.quo[i][5:0], st[9:8]};
        end
    end

    // stage 6: divider bits 3..2
    always_comb begin
        logic [9:0] st;
        n_s6 = r_s5;
        for (int i = 0; i < 3; i++) begin
            st          = div2(r_s5.rem[i], r_s5.num[i][3:2], r_s5.mx);
            n_s6.rem[i] = st[7:0];
            n_s6.quo[i] = {r_s5.quo[i][5:0], st[9:8]};
        end
    end

    // stage 7: last divider bits, then the result color (converted, or the source channels kept)
    always_comb begin
        logic [9:0]      st;
        logic [2:0][7:0] q;
        n_s7 = r_s6;
        for (int i = 0; i < 3; i++) begin
            st   = div2(r_s6.rem[i], r_s6.num[i][1:0], r_s6.mx);
            q[i] = {r_s6.quo[i][5:0], st[9:8]};
        end
        n_s7.rem   = r_s6.rem;
        n_s7.quo   = q;
        n_s7.space = r_s6.src;
        n_s7.d_r   = r_s6.s_r;
        n_s7.d_g   = r_s6.s_g;
        n_s7.d_b   = r_s6.s_b;
        n_s7.d_c   = r_s6.s_c;
        n_s7.d_m   = r_s6.s_m;
        n_s7.d_y   = r_s6.s_y;
        n_s7.d_k   = r_s6.s_k;
        if (r_s6.src == SP_BAD) begin
            n_s7.space = SP_GRAY;
        end else if (r_s6.dst != SP_BAD && r_s6.dst != r_s6.src) begin
            n_s7.space = r_s6.dst;
            n_s7.d_r   = 8'd0;
            n_s7.d_g   = 8'd0;
            n_s7.d_b   = 8'd0;
            n_s7.d_c   = 8'd0;
            n_s7.d_m   = 8'd0;
            n_s7.d_y   = 8'd0;
            n_s7.d_k   = 8'd0;
            case (r_s6.dst)
                SP_GRAY: begin
                    n_s7.d_g = r_s6.gray;
                end
                SP_RGB: begin
                    n_s7.d_r = r_s6.t_r;
                    n_s7.d_g = r_s6.t_g;
                    n_s7.d_b = r_s6.t_b;
                end
                default: begin
                    if (r_s6.src == SP_GRAY) begin
                        n_s7.d_k = ~r_s6.s_g;
                    end else if (r_s6.blk) begin
                        // all-black rgb
                        n_s7.d_k = 8'hff;
                    end else begin
                        n_s7.d_c = q[0];
                        n_s7.d_m = q[1];
                        n_s7.d_y = q[2];
                        n_s7.d_k = ~r_s6.mx;
                    end
                end
            endcase
        end
    end

    // stage 8: cmyk to rgb products of the result, for the packed word
    always_comb begin
        n_s8         = r_s7;
        n_s8.prod[0] = 16'(8'hff - r_s7.d_k) * 16'(8'hff - r_s7.d_c);
        n_s8.prod[1] = 16'(8'hff - r_s7.d_k) * 16'(8'hff - r_s7.d_m);
        n_s8.prod[2] = 16'(8'hff - r_s7.d_k) * 16'(8'hff - r_s7.d_y);
    end

    // stage 9: packed argb word and the output register
    always_comb begin
        logic [7:0] pr, pg, pb;
        if (r_s8.src == SP_BAD) begin
            pr = r_s8.d_r;
            pg = r_s8.d_g;
            pb = r_s8.d_b;
        end else begin
            case (r_s8.space)
                SP_GRAY: begin
                    pr = r_s8.d_g;
                    pg = r_s8.d_g;
                    pb = r_s8.d_g;
                end
                SP_RGB: begin
                    pr = r_s8.d_r;
                    pg = r_s8.d_g;
                    pb = r_s8.d_b;
                end
                default: begin
                    pr = div255(r_s8.prod[0]);
                    pg = div255(r_s8.prod[1]);
                    pb = div255(r_s8.prod[2]);
                end
            endcase
        end
        n_out.out_space   = r_s8.space;
        n_out.out_red     = r_s8.d_r;
        n_out.out_green   = r_s8.d_g;
        n_out.out_blue    = r_s8.d_b;
        n_out.out_cyan    = r_s8.d_c;
        n_out.out_magenta = r_s8.d_m;
        n_out.out_yellow  = r_s8.d_y;
        n_out.out_black   = r_s8.d_k;
        n_out.argb_word   = {r_s8.alpha, pb, pg, pr};
        n_out.bad_space   = (r_s8.src == SP_BAD) || (r_s8.dst == SP_BAD);
    end

    // valid bits move with the data, one stage per clock
    assign n_vld = {r_vld[NSTG-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_done <= r_vld[NSTG-1];
        end
    end

    // data registers, no reset
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        r_s5  <= n_s5;
        r_s6  <= n_s6;
        r_s7  <= n_s7;
        r_s8  <= n_s8;
        r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // a result cycle always traces back to an earlier command transfer
    `CSC_ASSERT(a_done_from_start, i_clk, i_rst_n,
        o_done |-> $past(accept, 9), "result without command")
    `CSC_ASSERT_NEVER(a_no_bad_space, i_clk, i_rst_n,
        o_done && (o_result.out_space == SP_BAD), "illegal result space")
    `CSC_ASSERT(a_gray_word, i_clk, i_rst_n,
        (o_done && !o_result.bad_space && (o_result.out_space == SP_GRAY)) |->
        ((o_result.argb_word[7:0] == o_result.out_green) &&
         (o_result.argb_word[23:16] == o_result.out_green) &&
         (o_result.out_red == 8'd0) && (o_result.out_black == 8'd0)),
        "gray result word mismatch")
    `CSC_ASSERT(a_rgb_word, i_clk, i_rst_n,
        (o_done && (o_result.out_space == SP_RGB)) |->
        ((o_result.argb_word[7:0] == o_result.out_red) &&
         (o_result.argb_word[15:8] == o_result.out_green) &&
         (o_result.argb_word[23:16] == o_result.out_blue)),
        "rgb result word mismatch")

endmodule

`default_nettype wire

// ===== bench/color_space_converter_tb.sv =====
// testbench for color_space_converter: directed and random pixels vs a built-in conversion model
`timescale 1ns / 1ps

module color_space_converter_tb;
    import csc_pkg::*;

    // generous ceiling on run length: every pixel waiting out the longest gap
    // plus the pipe depth still fits many times over
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PIPE_DEPTH   = 9;
    localparam int RANDOM_COUNT = 1050;
    localparam int BURST_BLOCK  = 40;

    // scaled cmyk channel to rgb channel, floor((255-k)(255-x)/255)
    function automatic int cmyk_chan_to_rgb(input int k, input int x);
        return ((255 - k) * (255 - x)) / 255;
    endfunction

    // expected conversion of one pixel command
    function automatic t_csc_out convert_pixel(input t_csc_in px);
        t_csc_out res;
        t_space src;
        t_space dst;
        t_space space;
        int sr, sg, sb, sc, sm, sy, sk;
        int dr, dg, db, dc, dm, dy, dk;
        int tr, tg, tb, pr, pg, pb;
        int ic, im, iy, den;
        bit bad;
        src = t_space'(px.src_space);
        dst = t_space'(px.dst_space);
        bad = (src == SP_BAD) || (dst == SP_BAD);
        {sr, sg, sb, sc, sm, sy, sk} = '0;
        {dr, dg, db, dc, dm, dy, dk} = '0;
        if (src == SP_BAD) begin
            // illegal source: every channel passes through, reported as gray
            dr = px.in_red;
            dg = px.in_green;
            db = px.in_blue;
            dc = px.in_cyan;
            dm = px.in_magenta;
            dy = px.in_yellow;
            dk = px.in_black;
            space = SP_GRAY;
            pr = dr;
            pg = dg;
            pb = db;
        end else begin
            // only the channels of the source space are taken
            case (src)
                SP_GRAY: sg = px.in_green;
                SP_RGB: begin
                    sr = px.in_red;
                    sg = px.in_green;
                    sb = px.in_blue;
                end
                default: begin
                    sc = px.in_cyan;
                    sm = px.in_magenta;
                    sy = px.in_yellow;
                    sk = px.in_black;
                end
            endcase
            if (dst == SP_BAD || dst == src) begin
                // same space or illegal target: color kept in its source space
                {dr, dg, db, dc, dm, dy, dk} = {sr, sg, sb, sc, sm, sy, sk};
                space = src;
            end else begin
                space = dst;
                case (dst)
                    SP_GRAY: begin
                        if (src == SP_CMYK) begin
                            tr = cmyk_chan_to_rgb(sk, sc);
                            tg = cmyk_chan_to_rgb(sk, sm);
                            tb = cmyk_chan_to_rgb(sk, sy);
                        end else begin
                            {tr, tg, tb} = {sr, sg, sb};
                        end
                        dg = (299 * tr + 587 * tg + 114 * tb) / 1000;
                    end
                    SP_RGB: begin
                        if (src == SP_CMYK) begin
                            dr = cmyk_chan_to_rgb(sk, sc);
                            dg = cmyk_chan_to_rgb(sk, sm);
                            db = cmyk_chan_to_rgb(sk, sy);
                        end else begin
                            {dr, dg, db} = {sg, sg, sg};
                        end
                    end
                    default: begin
                        if (src == SP_GRAY) begin
                            dk = 255 - sg;
                        end else if (sr == 0 && sg == 0 && sb == 0) begin
                            // pure black: no division, black channel saturates
                            dk = 255;
                        end else begin
                            ic = 255 - sr;
                            im = 255 - sg;
                            iy = 255 - sb;
                            dk = ic;
                            if (im < dk) dk = im;
                            if (iy < dk) dk = iy;
                            den = 255 - dk;
                            dc = ((ic - dk) * 255) / den;
                            dm = ((im - dk) * 255) / den;
                            dy = ((iy - dk) * 255) / den;
                        end
                    end
                endcase
            end
            // rgb view of the result for the packed word
            case (space)
                SP_GRAY: {pr, pg, pb} = {dg, dg, dg};
                SP_RGB:  {pr, pg, pb} = {dr, dg, db};
                default: begin
                    pr = cmyk_chan_to_rgb(dk, dc);
                    pg = cmyk_chan_to_rgb(dk, dm);
                    pb = cmyk_chan_to_rgb(dk, dy);
                end
            endcase
        end
        res.out_space   = space;
        res.out_red     = dr[7:0];
        res.out_green   = dg[7:0];
        res.out_blue    = db[7:0];
        res.out_cyan    = dc[7:0];
        res.out_magenta = dm[7:0];
        res.out_yellow  = dy[7:0];
        res.out_black   = dk[7:0];
        res.argb_word   = {px.in_alpha, pb[7:0], pg[7:0], pr[7:0]};
        res.bad_space   = bad;
        return res;
    endfunction

    // holds converted pixels in command order and matches them with the pipe output
    class csc_pixel_scoreboard;
        t_csc_out expected_pixels[$];
        int       mismatch_count = 0;

        function void note_command(input t_csc_in px);
            expected_pixels.push_back(convert_pixel(px));
        endfunction

        function bit field_ok(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s expected 0x%0h got 0x%0h", name, exp_v, act_v);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(input t_csc_out act);
            t_csc_out exp_px;
            bit ok;
            if (expected_pixels.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatch_count++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            ok = 1'b1;
            ok &= field_ok("out_space",   exp_px.out_space,   act.out_space);
            ok &= field_ok("out_red",     exp_px.out_red,     act.out_red);
            ok &= field_ok("out_green",   exp_px.out_green,   act.out_green);
            ok &= field_ok("out_blue",    exp_px.out_blue,    act.out_blue);
            ok &= field_ok("out_cyan",    exp_px.out_cyan,    act.out_cyan);
            ok &= field_ok("out_magenta", exp_px.out_magenta, act.out_magenta);
            ok &= field_ok("out_yellow",  exp_px.out_yellow,  act.out_yellow);
            ok &= field_ok("out_black",   exp_px.out_black,   act.out_black);
            ok &= field_ok("argb_word",   exp_px.argb_word,   act.argb_word);
            ok &= field_ok("bad_space",   exp_px.bad_space,   act.bad_space);
            if (!ok) mismatch_count++;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_csc_in   i_item = '0;
    logic      o_done;
    t_csc_out  o_result;

    csc_pixel_scoreboard sb = new;
    int        cycle_count = 0;

    color_space_converter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // watchdog: a hung pipe ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: the strobe lasts one cycle and cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) sb.check_result(o_result);
    end

    function automatic t_csc_in make_pixel(input t_space src, input t_space dst,
                                           input logic [7:0] a, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] m,
                                           input logic [7:0] y, input logic [7:0] k);
        t_csc_in px;
        px.src_space  = src;
        px.dst_space  = dst;
        px.in_alpha   = a;
        px.in_red     = r;
        px.in_green   = g;
        px.in_blue    = b;
        px.in_cyan    = c;
        px.in_magenta = m;
        px.in_yellow  = y;
        px.in_black   = k;
        return px;
    endfunction

    // channel value leaning toward the ends of the range
    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // space code, mostly legal, sometimes the illegal code
    function automatic t_space pick_space();
        if ($urandom_range(0, 7) == 0) return SP_BAD;
        return t_space'($urandom_range(0, 2));
    endfunction

    // one command transfer: start low for the requested gap, then hold start until busy is low
    task automatic send_pixel(input t_csc_in px, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = px;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        sb.note_command(px);
        @(negedge i_clk);
    endtask

    initial begin
        t_space spaces[4];
        t_csc_in px;
        int gap;
        bit burst;
        spaces = '{SP_GRAY, SP_RGB, SP_CMYK, SP_BAD};

        // synchronous reset, released away from the clock edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every source and target pair, illegal codes included
        foreach (spaces[s]) begin
            foreach (spaces[d]) begin
                send_pixel(make_pixel(spaces[s], spaces[d], 8'hA5, 8'd200, 8'd100, 8'd50,
                                      8'd30, 8'd60, 8'd90, 8'd120), $urandom_range(0, 2));
            end
        end
        // rgb black into cmyk takes the saturated black path
        send_pixel(make_pixel(SP_RGB, SP_CMYK, 8'hFF, 8'd0, 8'd0, 8'd0,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF), 0);
        // rgb white: zero black, zero inks
        send_pixel(make_pixel(SP_RGB, SP_CMYK, 8'h00, 8'd255, 8'd255, 8'd255,
                              8'd0, 8'd0, 8'd0, 8'd0), 0);
        send_pixel(make_pixel(SP_RGB, SP_GRAY, 8'hFF, 8'd255, 8'd255, 8'd255,
                              8'd0, 8'd0, 8'd0, 8'd0), 0);
        // gray ends into cmyk and rgb
        send_pixel(make_pixel(SP_GRAY, SP_CMYK, 8'h00, 8'd255, 8'd0, 8'd255,
                              8'd255, 8'd255, 8'd255, 8'd255), 1);
        send_pixel(make_pixel(SP_GRAY, SP_RGB, 8'hFF, 8'd0, 8'd255, 8'd0,
                              8'd0, 8'd0, 8'd0, 8'd0), 0);
        // full ink and no ink through the cmyk paths
        send_pixel(make_pixel(SP_CMYK, SP_RGB, 8'h80, 8'd0, 8'd0, 8'd0,
                              8'd255, 8'd255, 8'd255, 8'd255), 0);
        send_pixel(make_pixel(SP_CMYK, SP_GRAY, 8'h7F, 8'd255, 8'd255, 8'd255,
                              8'd0, 8'd0, 8'd0, 8'd0), 0);
        // illegal source with all channels at full scale
        send_pixel(make_pixel(SP_BAD, SP_RGB, 8'hFF, 8'd255, 8'd255, 8'd255,
                              8'd255, 8'd255, 8'd255, 8'd255), 0);

        // random pixels; some blocks run back to back, others with random gaps
        burst = 1'b0;
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n % BURST_BLOCK == 0) burst = ($urandom_range(0, 3) == 0);
            px = make_pixel(pick_space(), pick_space(), pick_chan(), pick_chan(),
                            pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                            pick_chan(), pick_chan());
            gap = burst ? 0 : $urandom_range(0, 9);
            send_pixel(px, gap);
        end
        start = 1'b0;

        // drain the pipe, then keep watching for stray transfers
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (sb.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/csc_pkg.sv
sv/color_space_converter.sv
bench/color_space_converter_tb.sv
